### rtl/qsed_pkg.sv
// Package: shared types, character codes and decode functions for the escape decoder.
`default_nettype none
package qsed_pkg;

  typedef enum logic [3:0] {
    MODE_START  = 4'd0,
    MODE_PASS   = 4'd1,
    MODE_QUOTED = 4'd2,
    MODE_ESC    = 4'd3,
    MODE_HEX1   = 4'd4,
    MODE_HEX2   = 4'd5,
    MODE_OCT1   = 4'd6,
    MODE_OCT2   = 4'd7,
    MODE_CLOSED = 4'd8,
    MODE_ERROR  = 4'd9
  } mode_t;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_X      = 8'h78;
  localparam logic [7:0] CH_ONE    = 8'h31;
  localparam logic [7:0] CH_SEVEN  = 8'h37;

  localparam int unsigned PART_W = 13;
  localparam logic signed [PART_W-1:0] OCT_BIAS = 13'sd48;
  localparam logic signed [PART_W-1:0] OCT_MAX  = 13'sd255;

  typedef struct packed {
    mode_t                     mode;
    logic [3:0]                first_digit;
    logic signed [PART_W-1:0]  partial_value;
  } dec_state_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       done_res;
    logic       status;
  } dec_result_t;

  localparam dec_state_t STATE_RESET = '{mode: MODE_START, first_digit: 4'd0,
                                         partial_value: '0};

  // {valid, nibble}
  function automatic logic [4:0] hex_value(input logic [7:0] b);
    logic [4:0] r;
    r = 5'd0;
    if (b >= 8'h41 && b <= 8'h46) r = {1'b1, 4'(b - 8'h37)};
    else if (b >= 8'h61 && b <= 8'h66) r = {1'b1, 4'(b - 8'h57)};
    else if (b >= 8'h30 && b <= 8'h39) r = {1'b1, b[3:0]};
    return r;
  endfunction

  // {valid, byte} for single-letter escapes
  function automatic logic [8:0] simple_escape(input logic [7:0] b);
    logic [8:0] r;
    r = 9'd0;
    case (b)
      8'h30: r = {1'b1, 8'd0};
      8'h6E: r = {1'b1, 8'd10};
      8'h72: r = {1'b1, 8'd13};
      8'h74: r = {1'b1, 8'd9};
      8'h76: r = {1'b1, 8'd11};
      8'h61: r = {1'b1, 8'd7};
      8'h62: r = {1'b1, 8'd8};
      8'h66: r = {1'b1, 8'd12};
      8'h27: r = {1'b1, 8'd39};
      8'h22: r = {1'b1, 8'd34};
      8'h5C: r = {1'b1, 8'd92};
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

### rtl/qsed_if.sv
// Interfaces: input and output valid/ready channels of the escape decoder.
`default_nettype none
interface qsed_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_byte;
  logic       present;
  logic       last;

  modport source (output valid, output char_byte, output present, output last,
                  input ready);
  modport sink (input valid, input char_byte, input present, input last,
                output ready);
endinterface

interface qsed_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       done_res;
  logic       status;

  modport source (output valid, output data_byte, output byte_valid,
                  output done_res, output status, input ready);
  modport sink (input valid, input data_byte, input byte_valid,
                input done_res, input status, output ready);
endinterface
`default_nettype wire

### rtl/qsed_step.sv
// Combinational decode of one byte: next decoder state and the result of the transaction.
`default_nettype none
module qsed_step (
  input  qsed_pkg::dec_state_t  st,
  input  logic [7:0]            char_byte,
  input  logic                  present,
  input  logic                  last,
  output qsed_pkg::dec_state_t  st_next,
  output qsed_pkg::dec_result_t res,
  output logic                  has_result
);
  import qsed_pkg::*;

  dec_state_t                upd;
  logic                      emit;
  logic [7:0]                data;
  logic [4:0]                hx;
  logic [8:0]                esc;
  logic signed [PART_W-1:0]  off;
  logic signed [PART_W-1:0]  oct_val;
  logic                      bad_end;

  assign hx      = hex_value(char_byte);
  assign esc     = simple_escape(char_byte);
  assign off     = $signed({5'b0, char_byte}) - OCT_BIAS;
  assign oct_val = st.partial_value + off;

  always_comb begin
    upd  = st;
    emit = 1'b0;
    data = 8'd0;
    if (present) begin
      unique case (st.mode)
        MODE_START: begin
          if (char_byte == CH_QUOTE) begin
            upd.mode = MODE_QUOTED;
          end else begin
            upd.mode = MODE_PASS;
            emit     = 1'b1;
            data     = char_byte;
          end
        end
        MODE_PASS: begin
          emit = 1'b1;
          data = char_byte;
        end
        MODE_QUOTED: begin
          if (char_byte == CH_QUOTE) begin
            upd.mode = MODE_CLOSED;
          end else if (char_byte == CH_BSLASH) begin
            upd.mode = MODE_ESC;
          end else begin
            emit = 1'b1;
            data = char_byte;
          end
        end
        MODE_ESC: begin
          if (esc[8]) begin
            emit     = 1'b1;
            data     = esc[7:0];
            upd.mode = MODE_QUOTED;
          end else if (char_byte == CH_X) begin
            upd.mode = MODE_HEX1;
          end else if (char_byte >= CH_ONE && char_byte <= CH_SEVEN) begin
            upd.partial_value = $signed({4'b0, char_byte[2:0], 6'b0});
            upd.mode          = MODE_OCT1;
          end else begin
            upd.mode = MODE_ERROR;
          end
        end
        MODE_HEX1: begin
          if (!hx[4]) begin
            upd.mode = MODE_ERROR;
          end else begin
            upd.first_digit = hx[3:0];
            upd.mode        = MODE_HEX2;
          end
        end
        MODE_HEX2: begin
          if (!hx[4]) begin
            upd.mode = MODE_ERROR;
          end else begin
            emit     = 1'b1;
            data     = {st.first_digit, hx[3:0]};
            upd.mode = MODE_QUOTED;
          end
        end
        MODE_OCT1: begin
          upd.partial_value = st.partial_value + (off <<< 3);
          upd.mode          = MODE_OCT2;
        end
        MODE_OCT2: begin
          if (oct_val > OCT_MAX) begin
            upd.mode = MODE_ERROR;
          end else begin
            emit     = 1'b1;
            data     = oct_val[7:0];
            upd.mode = MODE_QUOTED;
          end
        end
        default: ;  // closed or error: byte ignored
      endcase
    end
  end

  assign bad_end = !(upd.mode == MODE_START || upd.mode == MODE_PASS ||
                     upd.mode == MODE_CLOSED);

  assign st_next        = last ? STATE_RESET : upd;
  assign res.data_byte  = data;
  assign res.byte_valid = emit;
  assign res.done_res   = last;
  assign res.status     = last & bad_end;
  assign has_result     = emit | last;

endmodule
`default_nettype wire

### rtl/quoted_string_escape_decoder_top.sv
// Top level: input register, decode state and result register of the escape decoder.
// A result is registered when its byte leaves the input register.
// Throughput: one byte per cycle unless out_ch stalls; input and result registers let
// a new byte in while a result waits at the output, if the input register is empty.
// Non-final bytes that produce nothing (no byte, or ignored) leave no result transaction.
// Reset (rst, synchronous, active high) empties both registers and returns the
// decoder to the start-of-string mode.
`default_nettype none
module quoted_string_escape_decoder_top (
  input  logic              clk,
  input  logic              rst,
  qsed_in_if.sink           in_ch,
  qsed_out_if.source        out_ch
);
  import qsed_pkg::*;

  // Input register
  logic        s1_valid;
  logic [7:0]  s1_char;
  logic        s1_present;
  logic        s1_last;

  // Decoder state, carried between bytes of one string
  dec_state_t  st;
  dec_state_t  st_next;

  // Result register
  logic        out_valid;
  dec_result_t out_res;

  dec_result_t step_res;
  logic        step_has;
  logic        out_adv;    // result register can load this cycle
  logic        s1_move;    // input register hands its byte to the decoder

  assign out_adv      = !out_valid || out_ch.ready;
  assign s1_move      = s1_valid && out_adv;
  assign in_ch.ready  = !s1_valid || out_adv;

  qsed_step u_step (
    .st         (st),
    .char_byte  (s1_char),
    .present    (s1_present),
    .last       (s1_last),
    .st_next    (st_next),
    .res        (step_res),
    .has_result (step_has)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_char    <= in_ch.char_byte;
      s1_present <= in_ch.present;
      s1_last    <= in_ch.last;
    end
  end

  // State advances only when the byte really leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= STATE_RESET;
    end else if (s1_move) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_move) begin
      out_valid <= step_has;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && step_has) begin
      out_res <= step_res;
    end
  end

  assign out_ch.valid      = out_valid;
  assign out_ch.data_byte  = out_res.data_byte;
  assign out_ch.byte_valid = out_res.byte_valid;
  assign out_ch.done_res   = out_res.done_res;
  assign out_ch.status     = out_res.status;

  // A string's last byte leaves the decoder back at the start of a string
  a_last_resets: assert property (@(posedge clk) disable iff (rst)
    s1_move && s1_last |=> st.mode == MODE_START && st.partial_value == '0)
    else $error("decoder state not cleared after last byte");

  // A byte with no result must not create an output transaction
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    s1_move && !step_has |=> !out_valid)
    else $error("output transaction without a result");

  // Status is only reported together with the end of a string
  a_status_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_res.done_res |-> !out_res.status)
    else $error("status set on a non-final result");

  // Data is zero whenever no byte is carried
  a_data_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_res.byte_valid |-> out_res.data_byte == 8'd0)
    else $error("data byte set without byte_valid");

endmodule
`default_nettype wire

### bench/tb.sv
// Testbench: random and directed byte strings through the escape decoder, locally modelled.
`timescale 1ns / 100ps
module tb;
  import qsed_pkg::*;

  // Generous ceiling: about 1100 transactions with receiver stalls, plus drains.
  localparam int unsigned CYCLE_LIMIT = 200000;
  localparam int ASCII_ZERO = 48;

  typedef enum int {RX_OPEN, RX_LIGHT, RX_HEAVY, RX_PULSE} rx_style_t;
  typedef enum int {ESC_SIMPLE, ESC_HEX, ESC_OCTAL} esc_kind_t;
  typedef enum int {
    FLAW_BAD_LETTER, FLAW_BAD_HEX_HI, FLAW_BAD_HEX_LO, FLAW_CUT_ESCAPE,
    FLAW_CUT_HEX, FLAW_CUT_OCTAL, FLAW_NO_CLOSE
  } flaw_t;

  logic clk;
  logic rst;

  qsed_in_if  in_ch();
  qsed_out_if out_ch();

  quoted_string_escape_decoder_top dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Local copy of the decode state
  mode_t                 dec_mode;
  logic [7:0]            hex_hi;
  logic signed [12:0]    oct_acc;

  dec_result_t           expected_results[$];
  dec_result_t           oldest_result;
  logic [7:0]            string_bytes[$];

  int unsigned           mismatches;
  int unsigned           live_items;
  int unsigned           cycle_count;
  int unsigned           burst_left;
  int unsigned           stall_left;
  rx_style_t             stall_style;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Decode model
  // ---------------------------------------------------------------------------

  // {known, value} for the single-letter escapes
  function automatic logic [8:0] escape_char(input logic [7:0] b);
    case (b)
      "0":       return {1'b1, 8'd0};
      "n":       return {1'b1, 8'd10};
      "r":       return {1'b1, 8'd13};
      "t":       return {1'b1, 8'd9};
      "v":       return {1'b1, 8'd11};
      "a":       return {1'b1, 8'd7};
      "b":       return {1'b1, 8'd8};
      "f":       return {1'b1, 8'd12};
      "'":       return {1'b1, 8'd39};
      CH_QUOTE:  return {1'b1, 8'd34};
      CH_BSLASH: return {1'b1, 8'd92};
      default:   return 9'd0;
    endcase
  endfunction

  // Nibble value of a hex digit, -1 if the byte is no hex digit
  function automatic int hex_nibble(input logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b) - ASCII_ZERO;
    if (b >= "a" && b <= "f") return int'(b) - int'(8'h61) + 10;
    if (b >= "A" && b <= "F") return int'(b) - int'(8'h41) + 10;
    return -1;
  endfunction

  // Decodes one accepted transaction; queues the result it should cause, if any.
  task automatic predict_item(input logic [7:0] b, input logic p, input logic l);
    dec_result_t res;
    logic        emit;
    logic [7:0]  val;
    logic [8:0]  esc;
    int          nib;
    int          total;
    emit = 1'b0;
    val  = 8'h00;
    if (l || (p && dec_mode != MODE_CLOSED && dec_mode != MODE_ERROR)) live_items++;
    if (p) begin
      case (dec_mode)
        MODE_START: begin
          if (b == CH_QUOTE) begin
            dec_mode = MODE_QUOTED;
          end else begin
            dec_mode = MODE_PASS;
            emit = 1'b1;
            val = b;
          end
        end
        MODE_PASS: begin
          emit = 1'b1;
          val = b;
        end
        MODE_QUOTED: begin
          if (b == CH_QUOTE) begin
            dec_mode = MODE_CLOSED;
          end else if (b == CH_BSLASH) begin
            dec_mode = MODE_ESC;
          end else begin
            emit = 1'b1;
            val = b;
          end
        end
        MODE_ESC: begin
          esc = escape_char(b);
          if (esc[8]) begin
            emit = 1'b1;
            val = esc[7:0];
            dec_mode = MODE_QUOTED;
          end else if (b == CH_X) begin
            dec_mode = MODE_HEX1;
          end else if (b >= CH_ONE && b <= CH_SEVEN) begin
            oct_acc = 13'((int'(b) - ASCII_ZERO) * 64);
            dec_mode = MODE_OCT1;
          end else begin
            dec_mode = MODE_ERROR;
          end
        end
        MODE_HEX1: begin
          nib = hex_nibble(b);
          if (nib < 0) begin
            dec_mode = MODE_ERROR;
          end else begin
            hex_hi = 8'(nib);
            dec_mode = MODE_HEX2;
          end
        end
        MODE_HEX2: begin
          nib = hex_nibble(b);
          if (nib < 0) begin
            dec_mode = MODE_ERROR;
          end else begin
            emit = 1'b1;
            val = 8'(int'(hex_hi) * 16 + nib);
            dec_mode = MODE_QUOTED;
          end
        end
        MODE_OCT1: begin
          // middle digit is taken raw, so the sum may go negative
          oct_acc = oct_acc + 13'((int'(b) - ASCII_ZERO) * 8);
          dec_mode = MODE_OCT2;
        end
        MODE_OCT2: begin
          total = int'(oct_acc) + int'(b) - ASCII_ZERO;
          if (total > 255) begin
            dec_mode = MODE_ERROR;
          end else begin
            emit = 1'b1;
            val = 8'(total);
            dec_mode = MODE_QUOTED;
          end
        end
        default: begin
          // closed or failed: byte dropped
        end
      endcase
    end
    res.data_byte  = emit ? val : 8'h00;
    res.byte_valid = emit;
    res.done_res   = l;
    res.status     = l && !(dec_mode inside {MODE_START, MODE_PASS, MODE_CLOSED});
    if (l) begin
      dec_mode = MODE_START;
      hex_hi   = 8'h00;
      oct_acc  = '0;
    end
    if (emit || l) expected_results = {expected_results, res};
  endtask

  // Input side: every accepted transaction goes through the model
  always @(posedge clk) begin
    if (!rst && in_ch.valid && in_ch.ready)
      predict_item(in_ch.char_byte, in_ch.present, in_ch.last);
  end

  // ---------------------------------------------------------------------------
  // Result checking
  // ---------------------------------------------------------------------------

  function automatic void check_field(input string fname, input logic [7:0] want,
                                      input logic [7:0] got);
    if (want !== got) begin
      $display("%0t ns: %s mismatch, expected %02h, actual %02h",
               $time, fname, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst && out_ch.valid && out_ch.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t ns: result with none expected, expected nothing, actual %02h %b %b %b",
                 $time, out_ch.data_byte, out_ch.byte_valid, out_ch.done_res,
                 out_ch.status);
        mismatches++;
      end else begin
        oldest_result = expected_results.pop_front();
        check_field("data_byte",  oldest_result.data_byte,  out_ch.data_byte);
        check_field("byte_valid", 8'(oldest_result.byte_valid), 8'(out_ch.byte_valid));
        check_field("done_res",   8'(oldest_result.done_res),   8'(out_ch.done_res));
        check_field("status",     8'(oldest_result.status),     8'(out_ch.status));
      end
    end
  end

  // Receiver: changes its stall habit every so often, including spells of no stalls
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_style = rx_style_t'($urandom_range(0, 3));
      stall_left  = $urandom_range(16, 160);
    end
    stall_left--;
    case (stall_style)
      RX_OPEN:  out_ch.ready <= 1'b1;
      RX_LIGHT: out_ch.ready <= ($urandom_range(0, 3) != 0);
      RX_HEAVY: out_ch.ready <= ($urandom_range(0, 3) == 0);
      default:  out_ch.ready <= (stall_left[2:0] == 3'd0);
    endcase
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t ns: timeout with %0d results outstanding",
               $time, expected_results.size());
      $display("quoted_string_escape_decoder_top test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // One transaction; the sender runs in bursts with idle gaps between them.
  // Called at a rising edge, returns at the edge that accepts the transaction.
  task automatic send_char(input logic [7:0] b, input logic p, input logic l);
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap != 0) begin
        in_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    in_ch.valid     <= 1'b1;
    in_ch.char_byte <= b;
    in_ch.present   <= p;
    in_ch.last      <= l;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Lower valid and wait for every outstanding result
  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
  endtask

  // Sends string_bytes as one string, with stray empty transactions mixed in;
  // the end mark rides on the final byte or on an empty transaction of its own.
  task automatic send_string();
    int  i;
    logic split_end;
    split_end = (string_bytes.size() == 0) || ($urandom_range(0, 4) == 0);
    for (i = 0; i < string_bytes.size(); i++) begin
      if ($urandom_range(0, 11) == 0) send_char(8'($urandom), 1'b0, 1'b0);
      send_char(string_bytes[i], 1'b1, !split_end && (i == string_bytes.size() - 1));
    end
    if (split_end) send_char(8'($urandom), 1'b0, 1'b1);
  endtask

  // Appends one byte to the string under construction
  function automatic void append_byte(input logic [7:0] b);
    string_bytes = {string_bytes, b};
  endfunction

  function automatic logic [7:0] pick_hex_digit();
    int unsigned r;
    r = $urandom_range(0, 21);
    if (r < 10) return 8'(48 + r);
    if (r < 16) return 8'(8'h61 + r - 10);
    return 8'(8'h41 + r - 16);
  endfunction

  function automatic logic [7:0] pick_escape_letter();
    case ($urandom_range(0, 10))
      0:       return "0";
      1:       return "n";
      2:       return "r";
      3:       return "t";
      4:       return "v";
      5:       return "a";
      6:       return "b";
      7:       return "f";
      8:       return "'";
      9:       return CH_QUOTE;
      default: return CH_BSLASH;
    endcase
  endfunction

  // Octal trailing digit: mostly a real one, sometimes any byte at all
  function automatic logic [7:0] pick_octal_tail();
    if ($urandom_range(0, 4) == 0) return 8'($urandom);
    return 8'($urandom_range(48, 55));
  endfunction

  function automatic void add_escape();
    append_byte(CH_BSLASH);
    case (esc_kind_t'($urandom_range(0, 2)))
      ESC_SIMPLE: append_byte(pick_escape_letter());
      ESC_HEX: begin
        append_byte(CH_X);
        append_byte(pick_hex_digit());
        append_byte(pick_hex_digit());
      end
      default: begin
        append_byte(8'($urandom_range(49, 55)));
        append_byte(pick_octal_tail());
        append_byte(pick_octal_tail());
      end
    endcase
  endfunction

  function automatic void add_plain_char();
    logic [7:0] b;
    do b = 8'($urandom); while (b == CH_QUOTE || b == CH_BSLASH);
    append_byte(b);
  endfunction

  function automatic void add_bad_letter();
    logic [7:0] b;
    do b = 8'($urandom);
    while (escape_char(b) != 9'd0 || b == CH_X || (b >= CH_ONE && b <= CH_SEVEN));
    append_byte(b);
  endfunction

  function automatic void add_bad_hex();
    logic [7:0] b;
    do b = 8'($urandom); while (hex_nibble(b) >= 0);
    append_byte(b);
  endfunction

  // Injects one flaw at the tail of an open quoted string
  function automatic void add_flaw();
    flaw_t flaw;
    flaw = flaw_t'($urandom_range(0, 6));
    case (flaw)
      FLAW_BAD_LETTER: begin
        append_byte(CH_BSLASH);
        add_bad_letter();
      end
      FLAW_BAD_HEX_HI: begin
        append_byte(CH_BSLASH);
        append_byte(CH_X);
        add_bad_hex();
      end
      FLAW_BAD_HEX_LO: begin
        append_byte(CH_BSLASH);
        append_byte(CH_X);
        append_byte(pick_hex_digit());
        add_bad_hex();
      end
      FLAW_CUT_ESCAPE: append_byte(CH_BSLASH);
      FLAW_CUT_HEX: begin
        append_byte(CH_BSLASH);
        append_byte(CH_X);
        if ($urandom_range(0, 1) != 0) append_byte(pick_hex_digit());
      end
      FLAW_CUT_OCTAL: begin
        append_byte(CH_BSLASH);
        append_byte(8'($urandom_range(49, 55)));
        if ($urandom_range(0, 1) != 0) append_byte(pick_octal_tail());
      end
      default: begin
        // quote never closed
      end
    endcase
    // bytes after a hard error must be dropped
    if (flaw <= FLAW_BAD_HEX_LO)
      repeat ($urandom_range(0, 3)) append_byte(8'($urandom));
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty string, then an unquoted string with extreme bytes and an empty
  // transaction inside
  task automatic test_empty_and_plain();
    send_char(8'h00, 1'b0, 1'b1);
    send_char(8'hFF, 1'b1, 1'b0);
    send_char(8'hA5, 1'b0, 1'b0);
    send_char(8'h00, 1'b1, 1'b1);
  endtask

  // Quoted string: letter escape, mixed-case hex, top octal, negative octal,
  // closing quote and a byte after it that must be ignored
  task automatic test_quoted_escapes();
    send_char(CH_QUOTE,  1'b1, 1'b0);
    send_char(CH_BSLASH, 1'b1, 1'b0);
    send_char("n",       1'b1, 1'b0);
    send_char(CH_BSLASH, 1'b1, 1'b0);
    send_char(CH_X,      1'b1, 1'b0);
    send_char("a",       1'b1, 1'b0);
    send_char("F",       1'b1, 1'b0);
    send_char(CH_BSLASH, 1'b1, 1'b0);
    send_char("3",       1'b1, 1'b0);
    send_char("7",       1'b1, 1'b0);
    send_char("7",       1'b1, 1'b0);
    send_char(CH_BSLASH, 1'b1, 1'b0);
    send_char("1",       1'b1, 1'b0);
    send_char(8'h00,     1'b1, 1'b0);
    send_char(8'h00,     1'b1, 1'b0);
    send_char(CH_QUOTE,  1'b1, 1'b0);
    send_char("z",       1'b1, 1'b1);
  endtask

  // Unknown escape letter with a dropped byte after it, then a string cut
  // inside an escape
  task automatic test_format_errors();
    send_char(CH_QUOTE,  1'b1, 1'b0);
    send_char(CH_BSLASH, 1'b1, 1'b0);
    send_char("q",       1'b1, 1'b0);
    send_char("k",       1'b1, 1'b1);
    send_char(CH_QUOTE,  1'b1, 1'b0);
    send_char(CH_BSLASH, 1'b1, 1'b1);
  endtask

  // Mostly well-formed quoted strings with random content; some unquoted, some flawed
  task automatic test_random_strings(input int unsigned n_items);
    int unsigned target;
    int unsigned kind;
    target = live_items + n_items;
    while (live_items < target) begin
      string_bytes.delete();
      kind = $urandom_range(0, 9);
      if (kind == 0) begin
        repeat ($urandom_range(0, 8)) append_byte(8'($urandom));
        while (string_bytes.size() != 0 && string_bytes[0] == CH_QUOTE)
          string_bytes[0] = 8'($urandom);
      end else begin
        append_byte(CH_QUOTE);
        repeat ($urandom_range(0, 8)) begin
          if ($urandom_range(0, 2) == 0) add_escape();
          else add_plain_char();
        end
        if (kind <= 6) begin
          append_byte(CH_QUOTE);
          if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 4)) append_byte(8'($urandom));
        end else begin
          add_flaw();
        end
      end
      send_string();
    end
  endtask

  // Sender holds off until the decoder has nothing left to deliver
  task automatic test_drain_pause();
    wait_drained();
    repeat ($urandom_range(2, 12)) @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst             <= 1'b1;
    in_ch.valid     <= 1'b0;
    in_ch.char_byte <= 8'h00;
    in_ch.present   <= 1'b0;
    in_ch.last      <= 1'b0;
    dec_mode    = MODE_START;
    hex_hi      = 8'h00;
    oct_acc     = '0;
    mismatches  = 0;
    live_items  = 0;
    cycle_count = 0;
    burst_left  = 0;
    stall_left  = 0;
    stall_style = RX_OPEN;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    test_empty_and_plain();
    test_quoted_escapes();
    test_format_errors();
    test_random_strings(500);
    test_drain_pause();
    test_random_strings(500);

    // wait for all results, then let anything still in flight settle
    wait_drained();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("quoted_string_escape_decoder_top test passed");
    end else begin
      if (expected_results.size() != 0)
        $display("%0t ns: %0d results never arrived", $time, expected_results.size());
      $display("quoted_string_escape_decoder_top test failed");
    end
    $finish;
  end

endmodule
